@@ rtl/bba_pkg.sv @@
package bba_pkg;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_RESERVE = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NORUN = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    localparam int WORD_BITS = 32;

endpackage

@@ rtl/bitmap_block_allocator_unit.sv @@
// Channel   Direction  Accept                       Payload
// s_axis    in         s_axis_tvalid&s_axis_tready  mode, byte_address, block_count
// m_axis    out        m_axis_tvalid&m_axis_tready  result_address, status, used, free
// cfg       in         cfg_valid&cfg_ready          managed_blocks
//
// One request at a time: a single bit-test unit walks one block per cycle within a word,
// pausing at each bitmap word to read it, wait for the read and write it back if changed;
// a final state posts the result. Allocate scans up to limit blocks, then walks the found
// run again to mark it. Release walks count blocks, clipped at the limit, reserve a single
// block; zero-count requests and oversized allocates post at acceptance, other no-op
// requests skip the walk. Reset clears each bitmap word; input stalls on a held result.
module bitmap_block_allocator_unit #(
    parameter int MAX_BLOCKS  = 32768,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // lowest up: mode[1:0], byte_address[33:2], block_count[49:34], pad to 56
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // lowest up: result_address[31:0], status[33:32], used_total[49:34],
    // free_total[65:50], pad to 72
    output logic [71:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int WORDS = (MAX_BLOCKS + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(MAX_BLOCKS + 1);   // block index / count width
    localparam int LW    = (BW > 16) ? BW : 16;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_WAIT   = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_WRITE  = 4'd5;
    localparam logic [3:0] S_OUT    = 4'd6;

    logic [3:0]    state_reg, state_next;
    logic [15:0]   managed_reg;
    logic [LW-1:0] used_reg, used_next;
    logic [1:0]    mode_reg;
    logic [LW:0]   count_reg;
    logic [LW:0]   pos_reg, pos_next;     // current block index
    logic [LW:0]   stop_reg;              // last index + 1 of the walk
    logic [LW:0]   start_reg, start_next;
    logic [LW:0]   run_reg, run_next;
    logic          fill_reg;              // allocate: writing phase
    logic [31:0]   word_reg, word_next;
    logic [AW-1:0] clr_reg;
    logic          dirty_reg, dirty_next;
    logic [71:0]   out_reg;
    logic          ovalid_reg;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   rd_data, wr_data;

    logic [LW:0]   limit;
    logic [1:0]    in_mode;
    logic [31:0]   in_addr;
    logic [15:0]   in_count;
    logic [31:0]   first_blk;
    logic [LW:0]   in_first;
    logic [LW:0]   in_end;
    logic          first_ok;
    logic          zero_req;
    logic          big_alloc;
    logic          walk_req;

    assign in_mode  = s_axis_tdata[1:0];
    assign in_addr  = s_axis_tdata[33:2];
    assign in_count = s_axis_tdata[49:34];
    assign first_blk = in_addr / BLOCK_BYTES;
    assign limit = ((LW+1)'(managed_reg) > (LW+1)'(MAX_BLOCKS))
                 ? (LW+1)'(MAX_BLOCKS) : (LW+1)'(managed_reg);

    // request decode at the accepting edge
    assign first_ok  = first_blk < 32'(limit);
    assign in_first  = (LW+1)'(first_blk);
    assign in_end    = in_first + (LW+1)'(in_count);
    assign zero_req  = (in_mode inside {bba_pkg::MODE_ALLOC, bba_pkg::MODE_RELEASE})
                     && (in_count == 16'd0);
    assign big_alloc = (in_mode == bba_pkg::MODE_ALLOC) && ((LW+1)'(in_count) > limit);
    assign walk_req  = (in_mode == bba_pkg::MODE_ALLOC)
                     || ((in_mode inside {bba_pkg::MODE_RELEASE, bba_pkg::MODE_RESERVE})
                         && first_ok);

    bba_bitmap #(.WORDS(WORDS), .AW(AW)) u_map (
        .clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;

    logic       cur_bit;
    logic [4:0] bit_idx;
    assign bit_idx  = pos_reg[4:0];
    assign cur_bit  = word_reg[bit_idx];

    logic          done;
    logic [1:0]    st;
    logic          hit;
    logic [LW:0]   free_w;
    logic [31:0]   res_addr;

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        run_next   = run_reg;
        word_next  = word_reg;
        dirty_next = dirty_reg;
        rd_en      = 1'b0;
        rd_addr    = pos_reg[AW+4:5];
        wr_en      = 1'b0;
        wr_addr    = pos_reg[AW+4:5];
        wr_data    = word_reg;
        done       = 1'b0;
        st         = bba_pkg::ST_DONE;
        hit        = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                if (clr_reg == AW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                word_next  = rd_data;
                dirty_next = 1'b0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // one block per cycle through the single bit unit
                if (mode_reg == bba_pkg::MODE_ALLOC && !fill_reg)
                begin
                    if (!cur_bit)
                    begin
                        if (run_reg == '0)
                        begin
                            start_next = pos_reg;
                        end
                        run_next = run_reg + 1'b1;
                        if (run_reg + 1'b1 == count_reg)
                        begin
                            hit = 1'b1;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                else if (mode_reg == bba_pkg::MODE_ALLOC)
                begin
                    word_next[bit_idx] = 1'b1;
                    dirty_next = 1'b1;
                end
                else
                begin
                    // release or reserve
                    if (mode_reg == bba_pkg::MODE_RELEASE)
                    begin
                        if (cur_bit)
                        begin
                            word_next[bit_idx] = 1'b0;
                            dirty_next = 1'b1;
                            if (used_reg != '0)
                            begin
                                used_next = used_reg - 1'b1;
                            end
                        end
                    end
                    else if (!cur_bit)
                    begin
                        word_next[bit_idx] = 1'b1;
                        dirty_next = 1'b1;
                        used_next  = used_reg + 1'b1;
                    end
                end
                pos_next = pos_reg + 1'b1;
                if (hit)
                begin
                    // restart at run start and write the run
                    pos_next   = start_next;
                    state_next = S_RD;
                end
                else if (pos_reg + 1'b1 >= stop_reg)
                begin
                    state_next = S_WRITE;
                end
                else if (bit_idx == 5'd31)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                // write back the word just walked if it changed, then move on or finish
                wr_en   = dirty_reg;
                wr_addr = AW'((pos_reg - 1'b1) >> 5);
                if (pos_reg >= stop_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_OUT:
            begin
                done = 1'b1;
                state_next = S_IDLE;
                if (mode_reg == bba_pkg::MODE_ALLOC)
                begin
                    if (fill_reg)
                    begin
                        used_next = used_reg + LW'(count_reg);
                    end
                    else
                    begin
                        st = bba_pkg::ST_NORUN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign free_w = (limit > {1'b0, used_next}) ? (limit - {1'b0, used_next}) : '0;
    assign res_addr = (mode_reg == bba_pkg::MODE_ALLOC && fill_reg)
                    ? 32'(start_reg * (LW+1+32)'(BLOCK_BYTES)) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            managed_reg <= 16'd32768;
            used_reg    <= '0;
            ovalid_reg  <= 1'b0;
            fill_reg    <= 1'b0;
            mode_reg    <= bba_pkg::MODE_ALLOC;
            count_reg   <= '0;
            pos_reg     <= '0;
            stop_reg    <= '0;
            start_reg   <= '0;
            run_reg     <= '0;
            word_reg    <= '0;
            dirty_reg   <= 1'b0;
            out_reg     <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            word_reg  <= word_next;
            dirty_reg <= dirty_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                managed_reg <= cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                // latch the request and pick the walk bounds
                mode_reg  <= in_mode;
                count_reg <= (LW+1)'(in_count);
                fill_reg  <= 1'b0;
                run_reg   <= '0;
                start_reg <= '0;
                pos_reg   <= (in_mode == bba_pkg::MODE_ALLOC) ? '0 : in_first;
                if (in_mode == bba_pkg::MODE_ALLOC)
                begin
                    stop_reg <= limit;
                end
                else if (in_mode == bba_pkg::MODE_RELEASE)
                begin
                    stop_reg <= (in_end > limit) ? limit : in_end;
                end
                else
                begin
                    stop_reg <= in_first + 1'b1;
                end
                if (zero_req)
                begin
                    state_reg  <= S_IDLE;
                    ovalid_reg <= 1'b1;
                    out_reg    <= {6'd0, free_w[15:0], used_reg[15:0],
                                   bba_pkg::ST_ZERO, 32'd0};
                end
                else if (big_alloc)
                begin
                    state_reg  <= S_IDLE;
                    ovalid_reg <= 1'b1;
                    out_reg    <= {6'd0, free_w[15:0], used_reg[15:0],
                                   bba_pkg::ST_NORUN, 32'd0};
                end
                else if (walk_req)
                begin
                    state_reg <= S_RD;
                end
                else
                begin
                    state_reg <= S_OUT;
                end
            end
            else
            begin
                state_reg <= state_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
                run_reg   <= run_next;
                if (hit)
                begin
                    fill_reg <= 1'b1;
                    stop_reg <= start_next + count_reg;
                end
                if (done)
                begin
                    ovalid_reg <= 1'b1;
                    out_reg    <= {6'd0, free_w[15:0], used_next[15:0], st, res_addr};
                end
                else if (m_axis_tvalid && m_axis_tready)
                begin
                    ovalid_reg <= 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted while busy");
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= LW'(MAX_BLOCKS))
        else $error("used count overflow");
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("ready during clear");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped or changed while waiting");
`endif

endmodule

@@ rtl/bba_bitmap.sv @@
module bba_bitmap #(
    parameter int WORDS = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data
);

    logic [31:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_BLOCKS  = 32768;
    localparam int BLOCK_BYTES = 4096;
    localparam int CYCLE_LIMIT = 8000000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] result_address;
        logic [1:0]  status;
        logic [15:0] used_total;
        logic [15:0] free_total;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // lowest up: mode[1:0], byte_address[33:2], block_count[49:34], pad to 56
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // lowest up: result_address[31:0], status[33:32], used_total[49:34],
    // free_total[65:50], pad to 72
    logic [71:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // Model state: occupancy bits, used count and the managed limit
    bit          occ_bits [MAX_BLOCKS];
    int unsigned model_used;
    logic [15:0] managed_limit;

    alloc_result_t pending_results[$];
    bit          failed = 1'b0;
    bit          quiet;
    int unsigned cycles = 0;

    bitmap_block_allocator_unit #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .BLOCK_BYTES(BLOCK_BYTES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int unsigned eff_limit();
        return (managed_limit > MAX_BLOCKS) ? MAX_BLOCKS : managed_limit;
    endfunction

    function automatic bit block_used(int unsigned blk);
        if (blk >= MAX_BLOCKS)
            return 1'b1;
        return occ_bits[blk];
    endfunction

    // Apply one request to the model bitmap and return the expected result
    function automatic alloc_result_t apply_request(logic [1:0] mode, logic [31:0] addr,
                                                    logic [15:0] cnt);
        int unsigned lim;
        int unsigned first;
        int unsigned run;
        int unsigned start;
        int unsigned n;
        bit hit;
        alloc_result_t r;
        lim   = eff_limit();
        first = addr / BLOCK_BYTES;
        r     = '0;
        run   = 0;
        start = 0;
        hit   = 1'b0;
        case (mode)
            bba_pkg::MODE_ALLOC:
            begin
                if (cnt == 0)
                    r.status = bba_pkg::ST_ZERO;
                else
                begin
                    for (int unsigned i = 0; i < lim; i++)
                    begin
                        if (!block_used(i))
                        begin
                            if (run == 0)
                                start = i;
                            run++;
                            if (run == cnt)
                            begin
                                hit = 1'b1;
                                break;
                            end
                        end
                        else
                            run = 0;
                    end
                    if (hit)
                    begin
                        for (int unsigned i = 0; i < cnt; i++)
                            occ_bits[start + i] = 1'b1;
                        model_used += cnt;
                        r.result_address = start * BLOCK_BYTES;
                    end
                    else
                        r.status = bba_pkg::ST_NORUN;
                end
            end
            bba_pkg::MODE_RELEASE:
            begin
                if (cnt == 0)
                    r.status = bba_pkg::ST_ZERO;
                else if (first < lim)
                begin
                    // skip everything at or past the limit
                    n = (cnt < lim - first) ? cnt : lim - first;
                    for (int unsigned i = 0; i < n; i++)
                    begin
                        if (occ_bits[first + i])
                        begin
                            occ_bits[first + i] = 1'b0;
                            if (model_used > 0)
                                model_used--;
                        end
                    end
                end
            end
            bba_pkg::MODE_RESERVE:
            begin
                if (first < lim && !block_used(first))
                begin
                    occ_bits[first] = 1'b1;
                    model_used++;
                end
            end
            default: ;
        endcase
        r.used_total = model_used[15:0];
        r.free_total = (lim > model_used) ? 16'(lim - model_used) : 16'd0;
        return r;
    endfunction

    // Send one request; call and return at a falling edge. Valid stays high
    // after acceptance so back-to-back requests need no extra assignment.
    task automatic send_request(logic [1:0] mode, logic [31:0] addr, logic [15:0] cnt);
        if (!quiet && $urandom_range(0, 99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, cnt, addr, mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(apply_request(mode, addr, cnt));
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Write managed_blocks while the block is idle
    task automatic write_limit(logic [15:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        managed_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_byte_addr(int unsigned blk);
        return blk * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1);
    endfunction

    // Receiver side: stall at random unless in a quiet stretch
    always @(negedge clk)
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 21);

    // Compare each delivered result against the oldest prediction
    always @(posedge clk)
    begin
        alloc_result_t exp_r;
        alloc_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[31:0], m_axis_tdata[33:32],
                   m_axis_tdata[49:34], m_axis_tdata[65:50]};
            if (pending_results.size() == 0)
            begin
                $error("unexpected result %h", got);
                failed = 1'b1;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got.result_address !== exp_r.result_address)
                begin
                    $error("result_address exp %h got %h",
                           exp_r.result_address, got.result_address);
                    failed = 1'b1;
                end
                if (got.status !== exp_r.status)
                begin
                    $error("status exp %0d got %0d", exp_r.status, got.status);
                    failed = 1'b1;
                end
                if (got.used_total !== exp_r.used_total)
                begin
                    $error("used_total exp %0d got %0d", exp_r.used_total, got.used_total);
                    failed = 1'b1;
                end
                if (got.free_total !== exp_r.free_total)
                begin
                    $error("free_total exp %0d got %0d", exp_r.free_total, got.free_total);
                    failed = 1'b1;
                end
            end
        end
    end

    // Full capacity: whole-bitmap scans, clamp above the bitmap size, lowered
    // limit with used blocks stranded above it. Kept to a handful of requests.
    task automatic test_full_capacity();
        send_request(bba_pkg::MODE_RESERVE, pick_byte_addr(20000), 16'hFFFF);
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd32767);   // run past the reserved block fails
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd12000);
        send_request(bba_pkg::MODE_RESERVE, pick_byte_addr(MAX_BLOCKS - 1), 16'd0);
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd12766);   // fills the tail run
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd1);       // lands in the middle gap
        write_limit(16'hFFFF);                                 // clamps to the bitmap size
        send_request(bba_pkg::MODE_RELEASE, 32'd0, 16'd12000);
        send_request(bba_pkg::MODE_RESERVE, pick_byte_addr(MAX_BLOCKS), 16'd0); // past the bitmap
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd32768);   // more than free
        write_limit(16'd64);                                   // block 20000 and the tail stay used
        send_request(bba_pkg::MODE_RELEASE, pick_byte_addr(20000), 16'd5);
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd64);
        send_request(bba_pkg::MODE_RELEASE, 32'd0, 16'hFFFF);
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd65);
    endtask

    // Extremes of every field, each mode and each corner at small limits
    task automatic test_directed();
        write_limit(16'd0);
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd1);
        send_request(bba_pkg::MODE_RESERVE, 32'd0, 16'd0);
        send_request(bba_pkg::MODE_RELEASE, 32'd0, 16'd1);
        write_limit(16'd1);
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd2);
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd1);
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd0);
        send_request(bba_pkg::MODE_RELEASE, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(bba_pkg::MODE_RELEASE, 32'd4095, 16'd0);
        send_request(bba_pkg::MODE_RELEASE, 32'd4095, 16'd1);
        write_limit(16'd40);                                        // final partial word covered
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd33);
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd7);
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd1);
        send_request(bba_pkg::MODE_RESERVE, pick_byte_addr(35), 16'd0);   // already used
        send_request(bba_pkg::MODE_RELEASE, pick_byte_addr(36), 16'd100); // runs past the limit
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd4);
        send_request(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(bba_pkg::MODE_RESERVE, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(bba_pkg::MODE_RELEASE, pick_byte_addr(10), 16'd3);
        send_request(bba_pkg::MODE_ALLOC, 32'd0, 16'd3);
    endtask

    task automatic random_request();
        int unsigned lim;
        int unsigned pick;
        logic [15:0] cnt;
        lim  = eff_limit();
        pick = $urandom_range(0, 99);
        cnt  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, lim + 4))
                                           : 16'($urandom_range(1, 12));
        if (pick < 36)
            send_request(bba_pkg::MODE_ALLOC, $urandom, cnt);
        else if (pick < 66)
            send_request(bba_pkg::MODE_RELEASE,
                         pick_byte_addr($urandom_range(0, lim + 6)), cnt);
        else if (pick < 86)
            send_request(bba_pkg::MODE_RESERVE,
                         pick_byte_addr($urandom_range(0, lim + 6)), 16'($urandom));
        else if (pick < 90)
            send_request(MODE_UNUSED, $urandom, 16'($urandom));
        else
            send_request(2'($urandom_range(0, 2)), $urandom, 16'($urandom));
    endtask

    // Phases at assorted small limits; one phase runs with no stalls at all
    task automatic test_random();
        logic [15:0] limits [8] = '{16'd32, 16'd200, 16'd33, 16'd96, 16'd255,
                                    16'd63, 16'd150, 16'd2};
        for (int p = 0; p < 8; p++)
        begin
            write_limit(limits[p]);
            quiet = (p == 3);
            for (int k = 0; k < 65; k++)
                random_request();
            quiet = 1'b0;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        quiet         = 1'b0;
        model_used    = 0;
        managed_limit = 16'd32768;
        foreach (occ_bits[i])
            occ_bits[i] = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_full_capacity();
        test_directed();
        test_random();

        drain_results();
        repeat (50) @(negedge clk);
        if (!failed && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
